// ===== hw/rtl/rpic_pkg.sv =====
// ----------------------------------------------------------------------------
// rpic_pkg
// Shared types and constants for the RF pulse interval capture unit: phase
// codes, completion causes, configuration register indexes and defaults.
// ----------------------------------------------------------------------------
package rpic_pkg;

  // Default sizing
  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam int unsigned COUNT_WIDTH_DEF  = 16;

  // Configuration register indexes
  localparam logic [0:0] CFG_START_SILENCE = 1'b0;
  localparam logic [0:0] CFG_STOP_SILENCE  = 1'b1;

  // Configuration register reset values
  localparam logic [15:0] START_SILENCE_RST = 16'd10000;
  localparam logic [15:0] STOP_SILENCE_RST  = 16'd10000;

  // Grab phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_UNARMED = 3'd2,
    PH_ARMED   = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // Completion cause
  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_FULL    = 2'd1,
    CAUSE_TIMEOUT = 2'd2
  } cause_t;

endpackage

// ===== hw/rtl/rf_pulse_interval_capture_unit.sv =====
// ----------------------------------------------------------------------------
// rf_pulse_interval_capture_unit
// Edge-to-edge interval recorder for a received RF line, one timer tick or
// start command per input transfer, one result per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, cmd, rx_level): each transfer is either
//   a start command (cmd = 1) or one prescaled timer tick with the receiver
//   level. Output channel (out_valid / out_stall): exactly one result per input
//   transfer, in order: captured interval with its buffer index, completion
//   flag and cause, and the phase after the item.
//   Configuration: cfg_we writes cfg_data into the silence limit selected by
//   cfg_index; write only while no item is in flight.
//   Each item passes through the input register, then the result register, and
//   its result leaves the result register when out_stall is low. Throughput:
//   one item per cycle while out_stall does not hold a full result register;
//   the counter, edge compare and cursor update fit in the one stage between
//   the input register and the result register.
//   Reset (rst, synchronous): both channels empty, phase idle, counter and
//   cursor cleared, rising edge expected, limits back to 10000 ticks.
//   Stall: when out_stall holds a full result register, the input register
//   keeps its item and in_stall rises; with out_stall low, a new item is taken
//   every cycle even while a result is waiting to leave.
// ----------------------------------------------------------------------------
module rf_pulse_interval_capture_unit #(
  parameter int unsigned BUFFER_DEPTH = rpic_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH  = rpic_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic        rx_level,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sample_valid,
  output logic [7:0]  sample_index,
  output logic [15:0] interval_ticks,
  output logic        done_res,
  output logic [1:0]  done_cause,
  output logic [2:0]  phase_out
);
  import rpic_pkg::*;

  localparam int unsigned CUR_W = $clog2(BUFFER_DEPTH);

  // Configuration
  logic [15:0] start_silence;
  logic [15:0] stop_silence;

  // Input register
  logic s1_valid;
  logic s1_cmd;
  logic s1_lvl;

  // Grab state
  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, count_next;
  logic                   expect_rising, expect_next;
  logic                   last_level;
  logic [CUR_W-1:0]       write_cursor, cursor_next;

  // Result of the current item
  logic        r_sample;
  logic [7:0]  r_idx;
  logic [15:0] r_ival;
  logic        r_done;
  cause_t      r_cause;

  // Handshake control
  logic out_free;
  logic s2_go;
  logic accept;

  logic                   edge_hit;
  logic                   active;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [15:0]            limit;
  logic                   limit_hit;
  logic                   cursor_last;

  assign out_free = !out_valid || !out_stall;
  assign s2_go    = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_silence <= START_SILENCE_RST;
      stop_silence  <= STOP_SILENCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_SILENCE: start_silence <= cfg_data;
        CFG_STOP_SILENCE:  stop_silence  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: load on transfer, drop when passed on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd;
      s1_lvl <= rx_level;
    end
  end

  // Edge and limit detection
  assign edge_hit    = expect_rising ? (!last_level && s1_lvl) : (last_level && !s1_lvl);
  assign active      = (phase == PH_WAIT) || (phase == PH_UNARMED) || (phase == PH_ARMED);
  assign count_inc   = tick_count + 1'b1;
  assign limit       = (phase == PH_WAIT) ? start_silence : stop_silence;
  assign limit_hit   = 32'(count_inc) >= 32'(limit);
  assign cursor_last = write_cursor == CUR_W'(BUFFER_DEPTH - 1);

  // Next grab state and result
  always_comb begin
    phase_next  = phase;
    count_next  = tick_count;
    expect_next = expect_rising;
    cursor_next = write_cursor;
    r_sample    = 1'b0;
    r_idx       = '0;
    r_ival      = '0;
    r_done      = 1'b0;
    r_cause     = CAUSE_NONE;
    if (s1_cmd) begin
      phase_next  = PH_WAIT;
      count_next  = '0;
      cursor_next = '0;
      expect_next = 1'b1;
    end else if (active) begin
      if (edge_hit) begin
        count_next  = '0;
        expect_next = !expect_rising;
        if (phase != PH_WAIT) begin
          r_sample = 1'b1;
          r_idx    = 8'(write_cursor);
          r_ival   = 16'(tick_count);
          if (cursor_last) begin
            phase_next = PH_DONE;
            r_done     = 1'b1;
            r_cause    = CAUSE_FULL;
          end else begin
            cursor_next = write_cursor + 1'b1;
            phase_next  = PH_ARMED;
          end
        end
      end else begin
        count_next = count_inc;
        if (limit_hit) begin
          count_next = '0;
          if (phase == PH_WAIT) begin
            if (!s1_lvl) begin
              phase_next = PH_UNARMED;
            end
          end else if (phase == PH_ARMED) begin
            phase_next = PH_DONE;
            r_done     = 1'b1;
            r_cause    = CAUSE_TIMEOUT;
          end
        end
      end
    end
  end

  // Advance grab state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      expect_rising <= 1'b1;
      last_level    <= 1'b0;
      write_cursor  <= '0;
    end else if (s2_go) begin
      phase         <= phase_next;
      tick_count    <= count_next;
      expect_rising <= expect_next;
      last_level    <= s1_lvl;
      write_cursor  <= cursor_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      sample_valid   <= r_sample;
      sample_index   <= r_idx;
      interval_ticks <= r_ival;
      done_res       <= r_done;
      done_cause     <= r_cause;
      phase_out      <= phase_next;
    end
  end

endmodule

// ===== hw/rtl/rpic_checker.sv =====
// ----------------------------------------------------------------------------
// rpic_checker
// Port-level checks on the result channel of the pulse interval capture unit.
// ----------------------------------------------------------------------------
module rpic_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        sample_valid,
  input logic [7:0]  sample_index,
  input logic [15:0] interval_ticks,
  input logic        done_res,
  input logic [1:0]  done_cause,
  input logic [2:0]  phase_out
);
  import rpic_pkg::*;

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_valid) &&
      $stable(sample_index) && $stable(interval_ticks) && $stable(done_res) &&
      $stable(done_cause) && $stable(phase_out))
    else $error("result changed while stalled");

  // A captured interval only appears in capture or at its end
  a_sample_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid |-> (phase_out == PH_ARMED) || (phase_out == PH_DONE))
    else $error("sample outside capture phase");

  // Completion lands in the done phase with a cause
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> (phase_out == PH_DONE) && (done_cause != CAUSE_NONE))
    else $error("completion without done phase or cause");

  // A cause is only reported on completion
  a_cause_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> done_cause == CAUSE_NONE)
    else $error("cause without completion");

  // No sample means zero index and interval
  a_empty_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> (sample_index == 8'd0) && (interval_ticks == 16'd0))
    else $error("stray sample payload");

endmodule

bind rf_pulse_interval_capture_unit rpic_checker u_rpic_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .sample_valid   (sample_valid),
  .sample_index   (sample_index),
  .interval_ticks (interval_ticks),
  .done_res       (done_res),
  .done_cause     (done_cause),
  .phase_out      (phase_out)
);
